>>> src/mee_pkg.sv
// Shared types and constants of the matrix operation engine.
// Holds the transfer payload structs, the mode codes and the register indexes.
// Depends on nothing; every other file of the block imports it.
package mee_pkg;

  localparam int DefaultMaxDim = 8;
  localparam int FieldLimit    = 8;
  localparam int ValueW        = 32;
  localparam int DimW          = 4;
  localparam int IdxW          = 3;
  localparam int ProdW         = 2 * ValueW;
  localparam int TermW         = ProdW - 16;
  localparam int AccW          = TermW + 4;
  localparam int CfgIdxW       = 3;

  typedef enum logic [2:0] {
    OP_CONST     = 3'd0,
    OP_IDENTITY  = 3'd1,
    OP_SCALE     = 3'd2,
    OP_ADD       = 3'd3,
    OP_SUB       = 3'd4,
    OP_HADAMARD  = 3'd5,
    OP_MATMUL    = 3'd6,
    OP_TRANSPOSE = 3'd7
  } op_mode_e;

  typedef enum logic [1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OP_MODE   = 3'd0,
    CFG_OUT_ROWS  = 3'd1,
    CFG_OUT_COLS  = 3'd2,
    CFG_INNER_DIM = 3'd3,
    CFG_SCALAR    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IdxW-1:0]          row;
    logic [IdxW-1:0]          col;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]          out_row;
    logic [IdxW-1:0]          out_col;
    logic signed [ValueW-1:0] out_value;
    logic                     saturated;
    logic                     last;
  } out_item_t;

endpackage

>>> src/matrix_elementwise_and_matmul_engine.sv
// Matrix operation engine in signed Q16.16: two element stores, one shared multiplier.
// A small sequencer walks the output matrix and drives one registered output stage.
// Depends on mee_pkg.
//
// Write items for A or B produce no transfer. A compute item walks the output matrix in
// row-major order; every element passes through a memory read (READ), the shared 32x32
// multiplier (MUL) and the accumulator (ACC), then the output register is loaded (OUT).
// A matrix product element repeats READ, MUL and ACC once per inner index; every other
// element passes through them once. OUT holds while the output side stalls. The input side is
// ready only while no compute item is in progress. The stores have no reset: an entry must
// be written before a compute item reads it.
module matrix_elementwise_and_matmul_engine
  import mee_pkg::*;
#(
  parameter int MAX_DIM = DefaultMaxDim
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ValueW-1:0]     cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  localparam int Depth    = MAX_DIM * MAX_DIM;
  localparam int AddrW    = $clog2(Depth);
  localparam int DimBound = (MAX_DIM < FieldLimit) ? MAX_DIM : FieldLimit;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [2:0]               op_mode_q;
  logic [DimW-1:0]          out_rows_q, out_cols_q, inner_dim_q;
  logic signed [ValueW-1:0] scalar_q;

  logic [IdxW-1:0]          i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ValueW-1:0] a_rd_q, b_rd_q;
  logic signed [ValueW-1:0] mem_a [Depth];
  logic signed [ValueW-1:0] mem_b [Depth];

  logic                     out_valid_q;
  out_item_t                out_q;

  logic [DimW-1:0]          nr, nc, kn;
  logic [IdxW-1:0]          a_row, a_col, b_row, b_col;
  logic [AddrW-1:0]         a_addr, b_addr, wr_addr;
  logic                     in_fire, wr_ok, last_elem, out_free;
  logic signed [ValueW-1:0] mul_op;
  logic signed [ProdW-1:0]  prod_rnd;
  logic signed [TermW-1:0]  term_rnd;
  logic signed [AccW-1:0]   term;
  logic signed [AccW-1:0]   sat_hi, sat_lo;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = DimW'(1);
    end else if (d > DimW'(DimBound)) begin
      r = DimW'(DimBound);
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign nr = clamp_dim(out_rows_q);
  assign nc = clamp_dim(out_cols_q);
  assign kn = clamp_dim(inner_dim_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_elem  = ((DimW'(i_q) + DimW'(1)) == nr) && ((DimW'(j_q) + DimW'(1)) == nc);

  assign sat_hi = {{(AccW - ValueW){1'b0}}, 1'b0, {(ValueW - 1){1'b1}}};
  assign sat_lo = {{(AccW - ValueW){1'b1}}, 1'b1, {(ValueW - 1){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q   <= OP_MATMUL;
      out_rows_q  <= DimW'(8);
      out_cols_q  <= DimW'(8);
      inner_dim_q <= DimW'(8);
      scalar_q    <= 32'sh0001_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OP_MODE:   op_mode_q   <= cfg_wdata_i[2:0];
        CFG_OUT_ROWS:  out_rows_q  <= cfg_wdata_i[DimW-1:0];
        CFG_OUT_COLS:  out_cols_q  <= cfg_wdata_i[DimW-1:0];
        CFG_INNER_DIM: inner_dim_q <= cfg_wdata_i[DimW-1:0];
        CFG_SCALAR:    scalar_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_row = i_q;
    a_col = j_q;
    b_row = i_q;
    b_col = j_q;
    if (op_mode_q == OP_TRANSPOSE) begin
      a_row = j_q;
      a_col = i_q;
    end else if (op_mode_q == OP_MATMUL) begin
      a_col = k_q;
      b_row = k_q;
    end
  end

  assign a_addr  = AddrW'(a_row) * AddrW'(MAX_DIM) + AddrW'(a_col);
  assign b_addr  = AddrW'(b_row) * AddrW'(MAX_DIM) + AddrW'(b_col);
  assign wr_addr = AddrW'(in_data_i.row) * AddrW'(MAX_DIM) + AddrW'(in_data_i.col);
  assign wr_ok   = ({1'b0, in_data_i.row} < DimW'(DimBound))
                && ({1'b0, in_data_i.col} < DimW'(DimBound));

  always_ff @(posedge clk_i) begin
    if (in_fire && wr_ok && in_data_i.req_type == REQ_WRITE_A) begin
      mem_a[wr_addr] <= in_data_i.value;
    end
    if (in_fire && wr_ok && in_data_i.req_type == REQ_WRITE_B) begin
      mem_b[wr_addr] <= in_data_i.value;
    end
    if (state_q == ST_READ) begin
      a_rd_q <= mem_a[a_addr];
      b_rd_q <= mem_b[b_addr];
    end
  end

  assign mul_op = (op_mode_q == OP_SCALE) ? scalar_q : b_rd_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= a_rd_q * mul_op;
    end
  end

  assign prod_rnd = (prod_q + ProdW'(32768)) >>> 16;
  assign term_rnd = prod_rnd[TermW-1:0];

  always_comb begin
    unique case (op_mode_q)
      OP_CONST:     term = AccW'(scalar_q);
      OP_IDENTITY:  term = (i_q == j_q) ? AccW'(32'sh0001_0000) : '0;
      OP_ADD:       term = AccW'(a_rd_q) + AccW'(b_rd_q);
      OP_SUB:       term = AccW'(a_rd_q) - AccW'(b_rd_q);
      OP_TRANSPOSE: term = AccW'(a_rd_q);
      default:      term = AccW'(term_rnd);
    endcase
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    acc_d   = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.req_type == REQ_COMPUTE) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          acc_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC: begin
        acc_d = acc_q + term;
        if (op_mode_q == OP_MATMUL && (DimW'(k_q) + DimW'(1)) < kn) begin
          k_d     = k_q + IdxW'(1);
          state_d = ST_READ;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          k_d   = '0;
          acc_d = '0;
          if (last_elem) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_READ;
            if ((DimW'(j_q) + DimW'(1)) == nc) begin
              j_d = '0;
              i_d = i_q + IdxW'(1);
            end else begin
              j_d = j_q + IdxW'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_q.out_row <= i_q;
      out_q.out_col <= j_q;
      out_q.last    <= last_elem;
      if (acc_q > sat_hi) begin
        out_q.out_value <= sat_hi[ValueW-1:0];
        out_q.saturated <= 1'b1;
      end else if (acc_q < sat_lo) begin
        out_q.out_value <= sat_lo[ValueW-1:0];
        out_q.saturated <= 1'b1;
      end else begin
        out_q.out_value <= acc_q[ValueW-1:0];
        out_q.saturated <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/mee_checker.sv
// Port-level checker of the matrix operation engine, bound to the top level.
// Depends on mee_pkg and on matrix_elementwise_and_matmul_engine.
module mee_checker
  import mee_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // A pending result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // A compute transfer makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.req_type == REQ_COMPUTE |=> !in_ready_o)
    else $error("input ready right after a compute transfer");

  // While a result other than the final one is pending, the matrix walk is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input ready while the output matrix is incomplete");

endmodule

bind matrix_elementwise_and_matmul_engine mee_checker u_mee_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> test/matrix_elementwise_and_matmul_engine_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_elementwise_and_matmul_engine: a directed table, a full
// load of both element stores, random phases; checked by a Q16.16 predictor or fixed values.
// Depends on mee_pkg and the engine RTL only.
module matrix_elementwise_and_matmul_engine_test;
  import mee_pkg::*;

  localparam int ClkHalf = 4;
  localparam int DimBound = (DefaultMaxDim < FieldLimit) ? DefaultMaxDim : FieldLimit;
  localparam int StoreDepth = DefaultMaxDim * DefaultMaxDim;
  localparam int RandItems = 100;
  localparam int CalmItems = 40;
  localparam int SettleCycles = 40;
  localparam int MaxReported = 10;
  localparam longint CycleLimit = 5000000;
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  typedef enum bit {STEP_REGS, STEP_REQ} step_kind_e;

  typedef struct {
    step_kind_e        kind;
    op_mode_e          op;
    logic [DimW-1:0]   rows;
    logic [DimW-1:0]   cols;
    logic [DimW-1:0]   inner;
    logic [ValueW-1:0] scalar;
    in_item_t          req;
    bit                typed;
    logic [ValueW-1:0] want_value;
    bit                want_sat;
  } plan_step_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ValueW-1:0]  cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;

  logic signed [ValueW-1:0] a_store [StoreDepth];
  logic signed [ValueW-1:0] b_store [StoreDepth];
  op_mode_e                 mode_q;
  logic [DimW-1:0]          rows_q;
  logic [DimW-1:0]          cols_q;
  logic [DimW-1:0]          inner_q;
  logic signed [ValueW-1:0] scalar_q;

  out_item_t   owed_elems[$];
  plan_step_t  plan_q[$];
  int unsigned err_count = 0;
  int unsigned req_count = 0;
  int unsigned compute_count = 0;
  int unsigned elem_count = 0;
  int unsigned setting_count = 0;
  longint      cycle_count = 0;
  bit          calm = 1'b0;

  matrix_elementwise_and_matmul_engine DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= MaxReported) $display("%s", msg);
  endfunction

  function automatic longint q16_round(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic int unsigned active_dim(logic [DimW-1:0] d);
    if (d == 0) return 1;
    return (d > DimBound) ? DimBound : int'(d);
  endfunction

  function automatic longint a_at(int unsigned r, int unsigned c);
    return longint'(a_store[r * DefaultMaxDim + c]);
  endfunction

  function automatic longint b_at(int unsigned r, int unsigned c);
    return longint'(b_store[r * DefaultMaxDim + c]);
  endfunction

  function automatic out_item_t matrix_element(int unsigned i, int unsigned j, bit is_last);
    out_item_t e;
    longint acc;
    e.out_row = IdxW'(i);
    e.out_col = IdxW'(j);
    e.saturated = 1'b0;
    e.last = is_last;
    acc = 0;
    case (mode_q)
      OP_CONST:    acc = longint'(scalar_q);
      OP_IDENTITY: acc = (i == j) ? 64'sd65536 : 64'sd0;
      OP_SCALE:    acc = q16_round(longint'(scalar_q) * a_at(i, j));
      OP_ADD:      acc = a_at(i, j) + b_at(i, j);
      OP_SUB:      acc = a_at(i, j) - b_at(i, j);
      OP_HADAMARD: acc = q16_round(a_at(i, j) * b_at(i, j));
      OP_MATMUL: begin
        for (int unsigned k = 0; k < active_dim(inner_q); k++)
          acc += q16_round(a_at(i, k) * b_at(k, j));
      end
      default:     acc = a_at(j, i);
    endcase
    if (acc > QMax) begin
      acc = QMax;
      e.saturated = 1'b1;
    end else if (acc < QMin) begin
      acc = QMin;
      e.saturated = 1'b1;
    end
    e.out_value = acc[ValueW-1:0];
    return e;
  endfunction

  function automatic void predict_request(in_item_t it);
    int unsigned nr;
    int unsigned nc;
    nr = active_dim(rows_q);
    nc = active_dim(cols_q);
    case (it.req_type)
      REQ_WRITE_A: begin
        if (it.row < DimBound && it.col < DimBound)
          a_store[it.row * DefaultMaxDim + it.col] = it.value;
      end
      REQ_WRITE_B: begin
        if (it.row < DimBound && it.col < DimBound)
          b_store[it.row * DefaultMaxDim + it.col] = it.value;
      end
      REQ_COMPUTE: begin
        for (int unsigned i = 0; i < nr; i++)
          for (int unsigned j = 0; j < nc; j++)
            owed_elems.push_back(matrix_element(i, j, (i + 1 == nr) && (j + 1 == nc)));
      end
      default: ;
    endcase
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0001_0000;
      3, 4:    return $urandom;
      default: return ValueW'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 4'd15;
      1:       return 4'd0;
      2, 3:    return 4'd8;
      4:       return DimW'($urandom_range(0, 15));
      default: return DimW'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    int unsigned draw;
    draw = $urandom_range(0, 99);
    it.row = IdxW'($urandom_range(0, 7));
    it.col = IdxW'($urandom_range(0, 7));
    it.value = pick_value();
    if (draw < 40) it.req_type = REQ_WRITE_A;
    else if (draw < 75) it.req_type = REQ_WRITE_B;
    else if (draw < 95) it.req_type = REQ_COMPUTE;
    else it.req_type = REQ_NONE;
    return it;
  endfunction

  function automatic void add_regs(op_mode_e op, logic [DimW-1:0] rows, cols, inner,
                                   logic [ValueW-1:0] scalar);
    plan_step_t s;
    s.kind = STEP_REGS;
    s.op = op;
    s.rows = rows;
    s.cols = cols;
    s.inner = inner;
    s.scalar = scalar;
    s.typed = 1'b0;
    plan_q.push_back(s);
  endfunction

  function automatic void add_req(req_type_e t, logic [IdxW-1:0] r, c, logic [ValueW-1:0] v);
    plan_step_t s;
    s.kind = STEP_REQ;
    s.req.req_type = t;
    s.req.row = r;
    s.req.col = c;
    s.req.value = v;
    s.typed = 1'b0;
    plan_q.push_back(s);
  endfunction

  function automatic void add_typed(logic [ValueW-1:0] want, bit sat);
    plan_step_t s;
    s.kind = STEP_REQ;
    s.req.req_type = REQ_COMPUTE;
    s.req.row = '0;
    s.req.col = '0;
    s.req.value = '0;
    s.typed = 1'b1;
    s.want_value = want;
    s.want_sat = sat;
    plan_q.push_back(s);
  endfunction

  task automatic drive_request(in_item_t it, bit typed);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    req_count++;
    if (it.req_type == REQ_COMPUTE) compute_count++;
    if (!typed) predict_request(it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic await_drain();
    in_valid_i <= 1'b0;
    while (owed_elems.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_engine(op_mode_e op, logic [DimW-1:0] rows, cols, inner,
                                logic [ValueW-1:0] scalar);
    logic [ValueW-1:0] data [CFG_SCALAR + 1];
    data[CFG_OP_MODE] = ValueW'(op);
    data[CFG_OUT_ROWS] = ValueW'(rows);
    data[CFG_OUT_COLS] = ValueW'(cols);
    data[CFG_INNER_DIM] = ValueW'(inner);
    data[CFG_SCALAR] = scalar;
    for (int n = CFG_OP_MODE; n <= CFG_SCALAR; n++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(n);
      cfg_wdata_i <= data[n];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    mode_q = op;
    rows_q = rows;
    cols_q = cols;
    inner_q = inner;
    scalar_q = scalar;
    setting_count++;
  endtask

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  initial begin : sink_stall
    out_ready_i = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 150)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : score
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      elem_count++;
      if (owed_elems.size() == 0) begin
        note_error($sformatf("%0t: unexpected element r%0d c%0d v%h s%0b l%0b", $time,
                             out_data_o.out_row, out_data_o.out_col, out_data_o.out_value,
                             out_data_o.saturated, out_data_o.last));
      end else begin
        want = owed_elems.pop_front();
        if (out_data_o.out_row !== want.out_row || out_data_o.out_col !== want.out_col ||
            out_data_o.out_value !== want.out_value ||
            out_data_o.saturated !== want.saturated || out_data_o.last !== want.last)
          note_error($sformatf(
              "%0t: element mismatch, expected r%0d c%0d v%h s%0b l%0b, got r%0d c%0d v%h s%0b l%0b",
              $time, want.out_row, want.out_col, want.out_value, want.saturated, want.last,
              out_data_o.out_row, out_data_o.out_col, out_data_o.out_value,
              out_data_o.saturated, out_data_o.last));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("matrix_elementwise_and_matmul_engine_test: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t load;
    int unsigned rand_done;
    int unsigned burst;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OP_MODE;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    mode_q = OP_MATMUL;
    rows_q = 4'd8;
    cols_q = 4'd8;
    inner_q = 4'd8;
    scalar_q = 32'sh0001_0000;
    for (int n = 0; n < StoreDepth; n++) begin
      a_store[n] = '0;
      b_store[n] = '0;
    end

    add_regs(OP_CONST, 1, 1, 1, 32'h8000_0000);
    add_typed(32'h8000_0000, 1'b0);
    add_regs(OP_CONST, 0, 1, 1, 32'h7FFF_FFFF);
    add_typed(32'h7FFF_FFFF, 1'b0);
    add_regs(OP_IDENTITY, 15, 0, 1, 32'h0001_0000);
    add_req(REQ_COMPUTE, 0, 0, 32'h0000_0000);
    add_regs(OP_IDENTITY, 3, 8, 1, 32'h0001_0000);
    add_req(REQ_COMPUTE, 7, 7, 32'hFFFF_FFFF);
    add_req(REQ_NONE, 7, 7, 32'hFFFF_FFFF);
    add_req(REQ_WRITE_A, 0, 0, 32'h7FFF_FFFF);
    add_req(REQ_WRITE_B, 0, 0, 32'h7FFF_FFFF);
    add_regs(OP_ADD, 1, 1, 1, 32'h0001_0000);
    add_typed(32'h7FFF_FFFF, 1'b1);
    add_req(REQ_WRITE_B, 0, 0, 32'h8000_0000);
    add_regs(OP_SUB, 1, 1, 1, 32'h0001_0000);
    add_typed(32'h7FFF_FFFF, 1'b1);
    add_regs(OP_HADAMARD, 1, 1, 1, 32'h0001_0000);
    add_typed(32'h8000_0000, 1'b1);
    add_regs(OP_MATMUL, 1, 1, 0, 32'h0001_0000);
    add_typed(32'h8000_0000, 1'b1);
    add_req(REQ_WRITE_A, 0, 0, 32'h8000_0000);
    add_regs(OP_SCALE, 1, 1, 1, 32'h8000_0000);
    add_typed(32'h7FFF_FFFF, 1'b1);
    add_regs(OP_ADD, 1, 1, 1, 32'h8000_0000);
    add_typed(32'h8000_0000, 1'b1);
    add_req(REQ_WRITE_A, 0, 0, 32'h0000_0001);
    add_regs(OP_SCALE, 1, 1, 1, 32'h0000_8000);
    add_typed(32'h0000_0001, 1'b0);
    add_req(REQ_WRITE_A, 0, 0, 32'hFFFF_FFFF);
    add_typed(32'h0000_0000, 1'b0);
    add_req(REQ_WRITE_A, 7, 7, 32'h5A5A_A5A5);
    add_req(REQ_WRITE_B, 7, 7, 32'hA5A5_5A5A);
    add_regs(OP_TRANSPOSE, 1, 1, 1, 32'h0001_0000);
    add_typed(32'hFFFF_FFFF, 1'b0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (plan_q[n]) begin
      if (plan_q[n].kind == STEP_REGS) begin
        await_drain();
        program_engine(plan_q[n].op, plan_q[n].rows, plan_q[n].cols, plan_q[n].inner,
                       plan_q[n].scalar);
      end else begin
        if (plan_q[n].typed)
          owed_elems.push_back('{out_row: '0, out_col: '0, out_value: plan_q[n].want_value,
                                 saturated: plan_q[n].want_sat, last: 1'b1});
        drive_request(plan_q[n].req, plan_q[n].typed);
      end
    end

    for (int r = 0; r < DimBound; r++) begin
      for (int c = 0; c < DimBound; c++) begin
        load = '{req_type: REQ_WRITE_A, row: IdxW'(r), col: IdxW'(c), value: pick_value()};
        drive_request(load, 1'b0);
        load = '{req_type: REQ_WRITE_B, row: IdxW'(r), col: IdxW'(c), value: pick_value()};
        drive_request(load, 1'b0);
      end
    end

    rand_done = 0;
    while (rand_done < RandItems) begin
      await_drain();
      program_engine(op_mode_e'(3'($urandom_range(0, 7))), pick_dim(), pick_dim(), pick_dim(),
                     pick_value());
      burst = $urandom_range(4, 14);
      while (burst != 0 && rand_done < RandItems) begin
        load = random_request();
        if (rand_done >= RandItems - CalmItems) calm = 1'b1;
        drive_request(load, 1'b0);
        if (load.req_type != REQ_NONE) rand_done++;
        burst--;
      end
    end

    await_drain();
    $display("Sent %0d requests (%0d compute) under %0d register settings;",
             req_count, compute_count, setting_count);
    $display("checked %0d output element transfers in order, %0d failures.",
             elem_count, err_count);
    if (err_count == 0 && owed_elems.size() == 0) begin
      $display("matrix_elementwise_and_matmul_engine_test: done, clean");
    end else begin
      $display("matrix_elementwise_and_matmul_engine_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mee_pkg.sv
src/matrix_elementwise_and_matmul_engine.sv
src/mee_checker.sv
test/matrix_elementwise_and_matmul_engine_test.sv
